FILE: hdl/kcav_pkg.sv
// ----------------------------------------------------------------------------
// kcav_pkg
// shared constants and types for the kth coprime after value block
// ----------------------------------------------------------------------------
package kcav_pkg;
  localparam int unsigned ValueBits   = 20;
  localparam int unsigned MaxFactors  = 8;
  localparam int unsigned SearchLimit = 100000000;
  localparam int unsigned AnswerBits  = 27;
  localparam int unsigned CountBits   = 32;
  localparam int unsigned DivBits     = 32;
  localparam int unsigned IdxBits     = $clog2(MaxFactors);
  localparam int unsigned FcBits      = $clog2(MaxFactors + 1);
  localparam int unsigned SubBits     = MaxFactors;

  typedef struct packed {
    logic [DivBits-1:0] dividend;
    logic [DivBits-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic [DivBits-1:0] quotient;
    logic [DivBits-1:0] remainder;
  } div_rsp_t;
endpackage

FILE: hdl/kcav_if.sv
// ----------------------------------------------------------------------------
// kcav_in_if / kcav_out_if
// valid / ready channels for query and result items
// ----------------------------------------------------------------------------
interface kcav_in_if import kcav_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ValueBits-1:0] start_value;
  logic [ValueBits-1:0] modulus_value;
  logic [ValueBits-1:0] rank;
  modport source (output valid, start_value, modulus_value, rank, input ready);
  modport sink (input valid, start_value, modulus_value, rank, output ready);
endinterface

interface kcav_out_if import kcav_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [AnswerBits-1:0] answer;
  logic                  hit_limit;
  modport source (output valid, answer, hit_limit, input ready);
  modport sink (input valid, answer, hit_limit, output ready);
endinterface

FILE: hdl/kth_coprime_after_value_core.sv
// ----------------------------------------------------------------------------
// kth_coprime_after_value_core
// k-th integer above a start value that is coprime with a modulus
// ----------------------------------------------------------------------------
// One query at a time; ready is low while a query is in work, and one finished
// result item can wait in the output register while the next query is taken.
// All divisions run through one 32-bit restoring divider; products come from a
// combinational multiplier. Factoring takes up to about sqrt(p) trial
// divisions, and each of up to 29 coprime counts takes 1 + 2^f divisions,
// with f distinct prime factors.
module kth_coprime_after_value_core import kcav_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  kcav_in_if.sink   in_i,
  kcav_out_if.source out_o
);
  localparam logic [4:0] S_IDLE = 5'd0,  S_FTST = 5'd1,  S_FDIV = 5'd2,
                         S_FADD = 5'd3,  S_FSTR = 5'd4,  S_FRED = 5'd5,
                         S_FNXT = 5'd6,  S_FEND = 5'd7,  S_CNT0 = 5'd8,
                         S_CQ   = 5'd9,  S_CMUL = 5'd10, S_SPRD = 5'd11,
                         S_SDIV = 5'd12, S_SACC = 5'd13, S_CFIN = 5'd14,
                         S_TGT  = 5'd15, S_SRCH = 5'd16, S_SCMP = 5'd17,
                         S_OUT  = 5'd18, S_PMUL = 5'd19;

  localparam logic [1:0] C_TGT = 2'd0, C_MID = 2'd1, C_FIN = 2'd2;

  logic [4:0] st_q, st_d;
  logic [1:0] ctx_q, ctx_d;

  logic [ValueBits-1:0] x_q, x_d, k_q, k_d, m_q, m_d;
  logic [ValueBits:0]   dv_q, dv_d;
  logic [ValueBits-1:0] pf_q [MaxFactors];
  logic [ValueBits-1:0] pf_wdata;
  logic                 pf_we;
  logic [IdxBits-1:0]   pf_widx;
  logic [FcBits-1:0]    fc_q, fc_d;
  logic [DivBits-1:0]   rad_q, rad_d, phi_q, phi_d;
  logic [CountBits-1:0] tgt_q, tgt_d;
  logic [AnswerBits-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [DivBits-1:0]   n_q, n_d, rem_q, rem_d, nq_q, nq_d;
  logic [SubBits:0]     sub_q, sub_d;
  logic [IdxBits:0]     bi_q, bi_d;
  logic [DivBits-1:0]   prod_q, prod_d;
  logic                 odd_q, odd_d, big_q, big_d;
  logic signed [DivBits+1:0] part_q, part_d;
  logic [CountBits:0]   cnt_q, cnt_d;
  logic [AnswerBits-1:0] ans_q, ans_d;
  logic                 hit_q, hit_d, ov_q, ov_d;

  logic     dstart;
  div_req_t dreq;
  logic     ddone;
  div_rsp_t drsp;
  logic [2*DivBits-1:0] mul;
  logic [DivBits-1:0]   mop_a, mop_b;
  logic [CountBits+1:0] tsum;
  logic [AnswerBits:0]  msum;

  kcav_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(dstart),
    .req_i  (dreq),
    .done_o (ddone),
    .rsp_o  (drsp)
  );

  assign mul = mop_a * mop_b;

  always_comb begin
    st_d = st_q; ctx_d = ctx_q;
    x_d = x_q; k_d = k_q; m_d = m_q; dv_d = dv_q;
    fc_d = fc_q; rad_d = rad_q; phi_d = phi_q; tgt_d = tgt_q;
    lo_d = lo_q; hi_d = hi_q; n_d = n_q; rem_d = rem_q; nq_d = nq_q;
    sub_d = sub_q; bi_d = bi_q; prod_d = prod_q; odd_d = odd_q; big_d = big_q;
    part_d = part_q; cnt_d = cnt_q; ans_d = ans_q; hit_d = hit_q; ov_d = ov_q;
    dstart = 1'b0;
    dreq.dividend = '0;
    dreq.divisor  = 32'd1;
    mop_a = '0; mop_b = '0;
    pf_we = 1'b0; pf_widx = fc_q[IdxBits-1:0]; pf_wdata = m_q;
    tsum = '0; msum = '0;
    case (st_q)
      S_IDLE: begin
        if (in_i.valid) begin
          x_d = in_i.start_value; m_d = in_i.modulus_value; k_d = in_i.rank;
          fc_d = '0; rad_d = 32'd1; phi_d = 32'd1; dv_d = (ValueBits+1)'(2);
          st_d = S_FTST;
        end
      end
      S_FTST: begin
        mop_a = 32'(dv_q); mop_b = 32'(dv_q);
        if (m_q > 1 && mul <= 64'(m_q)) begin
          dstart = 1'b1; dreq.dividend = 32'(m_q); dreq.divisor = 32'(dv_q);
          st_d = S_FDIV;
        end else st_d = S_FEND;
      end
      S_FDIV: if (ddone) begin
        if (drsp.remainder == '0) begin
          st_d = (fc_q < FcBits'(MaxFactors)) ? S_FADD : S_FRED;
        end else st_d = S_FNXT;
      end
      S_FADD: begin
        pf_we = 1'b1; pf_wdata = dv_q[ValueBits-1:0];
        mop_a = rad_q; mop_b = 32'(dv_q); rad_d = mul[DivBits-1:0];
        st_d = S_FSTR;
      end
      S_FSTR: begin
        mop_a = phi_q; mop_b = 32'(dv_q) - 32'd1; phi_d = mul[DivBits-1:0];
        fc_d = fc_q + 1'b1;
        st_d = (m_q == '0) ? S_FEND : S_FRED;
      end
      S_FRED: begin
        dstart = 1'b1; dreq.dividend = 32'(m_q); dreq.divisor = 32'(dv_q);
        st_d = S_PMUL;
      end
      S_PMUL: if (ddone) begin
        if (drsp.remainder == '0) begin
          m_d = drsp.quotient[ValueBits-1:0];
          st_d = S_FRED;
        end else st_d = S_FNXT;
      end
      S_FNXT: begin
        dv_d = dv_q + 1'b1; st_d = S_FTST;
      end
      S_FEND: begin
        if (m_q > 1 && fc_q < FcBits'(MaxFactors)) begin
          pf_we = 1'b1;
          mop_a = rad_q; mop_b = 32'(m_q); rad_d = mul[DivBits-1:0];
          dv_d = {1'b0, m_q};
          st_d = S_FSTR;
          m_d = '0;
        end else begin
          n_d = 32'(x_q); ctx_d = C_TGT; st_d = S_CNT0;
        end
      end
      S_CNT0: begin
        dstart = 1'b1; dreq.dividend = n_q; dreq.divisor = rad_q;
        st_d = S_CQ;
      end
      S_CQ: if (ddone) begin
        nq_d = drsp.quotient; rem_d = drsp.remainder;
        st_d = S_CMUL;
      end
      S_CMUL: begin
        mop_a = nq_q; mop_b = phi_q;
        cnt_d = (CountBits+1)'(mul);
        part_d = '0; sub_d = '0;
        st_d = S_SPRD;
        prod_d = 32'd1; odd_d = 1'b0; big_d = 1'b0; bi_d = '0;
      end
      S_SPRD: begin
        if (sub_q[SubBits-1:0] == '0 && sub_q != '0 ||
            sub_q >= ((SubBits+1)'(1) << fc_q)) begin
          st_d = S_CFIN;
        end else if (bi_q == (IdxBits+1)'(fc_q)) begin
          st_d = S_SDIV;
        end else begin
          if (sub_q[bi_q[IdxBits-1:0]]) begin
            mop_a = prod_q; mop_b = 32'(pf_q[bi_q[IdxBits-1:0]]);
            if (mul[2*DivBits-1:DivBits] != '0) big_d = 1'b1;
            prod_d = mul[DivBits-1:0];
            odd_d = !odd_q;
          end
          bi_d = bi_q + 1'b1;
        end
      end
      S_SDIV: begin
        dstart = 1'b1; dreq.dividend = rem_q;
        dreq.divisor = big_q ? 32'hFFFF_FFFF : prod_q;
        st_d = S_SACC;
      end
      S_SACC: if (ddone) begin
        if (!big_q) begin
          if (odd_q) part_d = part_q - $signed({2'b00, drsp.quotient});
          else       part_d = part_q + $signed({2'b00, drsp.quotient});
        end
        sub_d = sub_q + 1'b1;
        prod_d = 32'd1; odd_d = 1'b0; big_d = 1'b0; bi_d = '0;
        st_d = S_SPRD;
      end
      S_CFIN: begin
        cnt_d = cnt_q + (CountBits+1)'(part_q);
        case (ctx_q)
          C_TGT:   st_d = S_TGT;
          C_MID:   st_d = S_SCMP;
          C_FIN:   st_d = S_OUT;
          default: st_d = S_IDLE;
        endcase
      end
      S_TGT: begin
        tsum = (CountBits+2)'(cnt_q) + (CountBits+2)'(k_q);
        tgt_d = (tsum > (CountBits+2)'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                       : tsum[CountBits-1:0];
        lo_d = AnswerBits'(1); hi_d = AnswerBits'(SearchLimit);
        st_d = S_SRCH;
      end
      S_SRCH: begin
        msum = {1'b0, lo_q} + {1'b0, hi_q};
        if (lo_q < hi_q) begin
          n_d = 32'(msum[AnswerBits:1]); ctx_d = C_MID;
        end else begin
          n_d = 32'(lo_q); ctx_d = C_FIN;
        end
        st_d = S_CNT0;
      end
      S_SCMP: begin
        if (cnt_q >= (CountBits+1)'(tgt_q)) hi_d = n_q[AnswerBits-1:0];
        else lo_d = n_q[AnswerBits-1:0] + 1'b1;
        st_d = S_SRCH;
      end
      S_OUT: begin
        if (!ov_q || out_o.ready) begin
          ans_d = lo_q; hit_d = cnt_q < (CountBits+1)'(tgt_q);
          ov_d = 1'b1; st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
    if (out_o.valid && out_o.ready && st_q != S_OUT) ov_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; ctx_q <= C_TGT; ov_q <= 1'b0;
      fc_q <= '0; rad_q <= 32'd1; phi_q <= 32'd1; tgt_q <= '0;
      lo_q <= AnswerBits'(1); hi_q <= AnswerBits'(SearchLimit);
    end else begin
      st_q <= st_d; ctx_q <= ctx_d; ov_q <= ov_d;
      fc_q <= fc_d; rad_q <= rad_d; phi_q <= phi_d; tgt_q <= tgt_d;
      lo_q <= lo_d; hi_q <= hi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; k_q <= k_d; m_q <= m_d; dv_q <= dv_d;
    n_q <= n_d; rem_q <= rem_d; nq_q <= nq_d; sub_q <= sub_d; bi_q <= bi_d;
    prod_q <= prod_d; odd_q <= odd_d; big_q <= big_d; part_q <= part_d;
    cnt_q <= cnt_d; ans_q <= ans_d; hit_q <= hit_d;
    if (pf_we) pf_q[pf_widx] <= pf_wdata;
  end

  assign in_i.ready      = (st_q == S_IDLE);
  assign out_o.valid     = ov_q;
  assign out_o.answer    = ans_q;
  assign out_o.hit_limit = hit_q;
endmodule

FILE: hdl/kcav_divider.sv
// ----------------------------------------------------------------------------
// kcav_divider
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module kcav_divider import kcav_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  div_req_t req_i,
  output logic     done_o,
  output div_rsp_t rsp_o
);
  localparam int unsigned CntBits = $clog2(DivBits + 1);

  logic [DivBits-1:0] quo_q, quo_d, rem_q, rem_d, dsr_q, dsr_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic [DivBits:0]   trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[DivBits-1]} - {1'b0, dsr_q};
    if (start_i) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
      cnt_d  = CntBits'(DivBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DivBits]) begin
        rem_d = trial[DivBits-1:0];
        quo_d = {quo_q[DivBits-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DivBits-2:0], quo_q[DivBits-1]};
        quo_d = {quo_q[DivBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o         = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;
endmodule
